// ===== rtl/ucc_pkg.sv =====
// ----------------------------------------------------------------------------
// ucc_pkg
// shared types, code point limits and the case map of the utf-8 case converter
// ----------------------------------------------------------------------------
package ucc_pkg;

    typedef logic [20:0] t_code;

    // one work entry between the decode front and the encode back
    typedef struct packed {
        t_code code;
        logic  empty;      // closing entry with no byte
        logic  run_last;
        logic  done;
    } t_job;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    localparam t_code CP_MAX    = 21'h10FFFF;
    localparam t_code CP_1B_MAX = 21'h00007F;
    localparam t_code CP_2B_MAX = 21'h0007FF;
    localparam t_code CP_3B_MAX = 21'h00FFFF;

    localparam t_code ASC_UP_LO = 21'h000041;
    localparam t_code ASC_UP_HI = 21'h00005A;
    localparam t_code ASC_LO_LO = 21'h000061;
    localparam t_code ASC_LO_HI = 21'h00007A;
    localparam t_code CYR_UP_LO = 21'h000410;
    localparam t_code CYR_UP_HI = 21'h00042F;
    localparam t_code CYR_LO_LO = 21'h000430;
    localparam t_code CYR_LO_HI = 21'h00044F;
    localparam t_code CYR_YO_UP = 21'h000401;
    localparam t_code CYR_YO_LO = 21'h000451;
    localparam t_code CASE_OFS  = 21'h000020;

    localparam logic MODE_UPPER = 1'b0;
    localparam logic MODE_LOWER = 1'b1;

    function automatic t_code map_case(t_code cp, logic mode);
        t_code res;
        res = cp;
        if (mode == MODE_UPPER) begin
            if ((cp >= ASC_LO_LO && cp <= ASC_LO_HI) || (cp >= CYR_LO_LO && cp <= CYR_LO_HI)) begin
                res = cp - CASE_OFS;
            end else if (cp == CYR_YO_LO) begin
                res = CYR_YO_UP;
            end
        end else begin
            if ((cp >= ASC_UP_LO && cp <= ASC_UP_HI) || (cp >= CYR_UP_LO && cp <= CYR_UP_HI)) begin
                res = cp + CASE_OFS;
            end else if (cp == CYR_YO_UP) begin
                res = CYR_YO_LO;
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/ucc_if.sv =====
// ----------------------------------------------------------------------------
// ucc stream interfaces
// valid/ready channels for the input bytes and the result bytes
// ----------------------------------------------------------------------------
interface ucc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       string_end;

    modport source (output valid, output in_byte, output string_end, input ready);
    modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

interface ucc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_done;

    modport source (output valid, output out_byte, output byte_valid, output run_last,
                    output string_done, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                    input string_done, output ready);
endinterface

// ===== rtl/ucc_front.sv =====
// ----------------------------------------------------------------------------
// ucc_front
// accepts input bytes, collects code points and queues up to two per item
// ----------------------------------------------------------------------------
module ucc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ucc_in_if.sink          i_in,
    input  logic            i_q_full,
    output logic            o_push,
    output ucc_pkg::t_job   o_push_job
);

    ucc_pkg::t_code r_pend, n_pend;
    logic [1:0]     r_need, n_need;
    logic           r_spill_valid, n_spill_valid;
    ucc_pkg::t_job  r_spill, n_spill;

    logic           acc;
    logic           cont;
    logic           handled;
    logic           v_a, v_b, v_c;
    ucc_pkg::t_code c_a, c_b, c_c;
    logic           ok_a, ok_c;
    logic           has_first, has_second;
    ucc_pkg::t_code first_code, second_code;
    ucc_pkg::t_code cont_bits;

    always_comb begin
        i_in.ready = !r_spill_valid && !i_q_full;
        acc        = i_in.valid && i_in.ready;
        cont       = (i_in.in_byte[7:6] == 2'b10);

        n_pend    = r_pend;
        n_need    = r_need;
        handled   = 1'b0;
        v_a       = 1'b0;
        c_a       = r_pend;
        v_b       = 1'b0;
        c_b       = {13'd0, i_in.in_byte};
        cont_bits = '0;

        // open sequence: continue it or flush the partial value
        if (r_need != 2'd0) begin
            if (cont) begin
                handled = 1'b1;
                n_need  = 2'(r_need - 2'd1);
                case (n_need)
                    2'd2:    cont_bits = {3'd0, i_in.in_byte[5:0], 12'd0};
                    2'd1:    cont_bits = {9'd0, i_in.in_byte[5:0], 6'd0};
                    default: cont_bits = {15'd0, i_in.in_byte[5:0]};
                endcase
                n_pend = r_pend | cont_bits;
                if (n_need == 2'd0) begin
                    v_a    = 1'b1;
                    c_a    = n_pend;
                    n_pend = '0;
                end
            end else begin
                v_a    = 1'b1;
                c_a    = r_pend;
                n_pend = '0;
                n_need = 2'd0;
            end
        end

        if (!handled) begin
            if (!i_in.in_byte[7]) begin
                v_b = 1'b1;
            end else if (i_in.in_byte[7:5] == 3'b110) begin
                n_pend = {10'd0, i_in.in_byte[4:0], 6'd0};
                n_need = 2'd1;
            end else if (i_in.in_byte[7:4] == 4'b1110) begin
                n_pend = {5'd0, i_in.in_byte[3:0], 12'd0};
                n_need = 2'd2;
            end else if (i_in.in_byte[7:3] == 5'b11110) begin
                n_pend = {i_in.in_byte[2:0], 18'd0};
                n_need = 2'd3;
            end else begin
                v_b = 1'b1;   // stray continuation or f8..ff
            end
        end

        // end of text inside a sequence
        c_c = n_pend;
        v_c = i_in.string_end && (n_need != 2'd0);
        if (i_in.string_end) begin
            n_pend = '0;
            n_need = 2'd0;
        end

        ok_a = v_a && (c_a <= ucc_pkg::CP_MAX);
        ok_c = v_c && (c_c <= ucc_pkg::CP_MAX);

        has_first   = ok_a || v_b || ok_c;
        has_second  = ok_a && (v_b || ok_c);
        first_code  = ok_a ? c_a : (v_b ? c_b : c_c);
        second_code = v_b ? c_b : c_c;

        n_spill.code     = second_code;
        n_spill.empty    = 1'b0;
        n_spill.run_last = 1'b1;
        n_spill.done     = i_in.string_end;

        n_spill_valid = r_spill_valid;
        if (r_spill_valid) begin
            o_push        = !i_q_full;
            o_push_job    = r_spill;
            n_spill_valid = i_q_full;
        end else begin
            o_push = acc && (has_first || i_in.string_end);
            if (has_first) begin
                o_push_job.code     = first_code;
                o_push_job.empty    = 1'b0;
                o_push_job.run_last = !has_second;
                o_push_job.done     = i_in.string_end && !has_second;
            end else begin
                o_push_job.code     = '0;
                o_push_job.empty    = 1'b1;
                o_push_job.run_last = 1'b1;
                o_push_job.done     = 1'b1;
            end
            n_spill_valid = acc && has_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend        <= '0;
            r_need        <= 2'd0;
            r_spill_valid <= 1'b0;
        end else begin
            r_spill_valid <= n_spill_valid;
            if (acc) begin
                r_pend <= n_pend;
                r_need <= n_need;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && has_second) begin
            r_spill <= n_spill;
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in.string_end) |=> (r_need == 2'd0 && r_pend == '0))
        else $error("sequence state not cleared after end of text");

    a_push_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && !r_spill_valid) |-> acc)
        else $error("queue push without an accepted item");

endmodule

// ===== rtl/ucc_fifo.sv =====
// ----------------------------------------------------------------------------
// ucc_fifo
// short queue of code point entries between decode and encode
// ----------------------------------------------------------------------------
module ucc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ucc_pkg::t_job   i_data,
    output logic            o_full,
    output logic            o_valid,
    output ucc_pkg::t_job   o_data,
    input  logic            i_pop
);

    ucc_pkg::t_job              r_mem [ucc_pkg::QDEPTH];
    logic [ucc_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [ucc_pkg::QPTR_W:0]   r_cnt;

    always_comb begin
        o_full  = (r_cnt == (ucc_pkg::QPTR_W+1)'(ucc_pkg::QDEPTH));
        o_valid = (r_cnt != '0);
        o_data  = r_mem[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + (ucc_pkg::QPTR_W)'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + (ucc_pkg::QPTR_W)'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (ucc_pkg::QPTR_W+1)'(1);
                2'b01:   r_cnt <= r_cnt - (ucc_pkg::QPTR_W+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty queue");

endmodule

// ===== rtl/ucc_back.sv =====
// ----------------------------------------------------------------------------
// ucc_back
// case-maps queued code points and sends them out as utf-8 bytes
// ----------------------------------------------------------------------------
module ucc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_case_mode,
    input  logic            i_q_valid,
    input  ucc_pkg::t_job   i_q_data,
    output logic            o_pop,
    ucc_out_if.source       o_out
);

    logic             r_cur_valid, n_cur_valid;
    logic [3:0][7:0]  r_bytes, n_bytes;
    logic [2:0]       r_left, n_left;
    logic             r_empty, r_last, r_done;

    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_bv, r_out_last, r_out_done;

    ucc_pkg::t_code   cp;
    logic [3:0][7:0]  enc_bytes;
    logic [2:0]       enc_len;
    logic             can_move, move, cur_free;

    // map and encode the queue head
    always_comb begin
        cp        = ucc_pkg::map_case(i_q_data.code, i_case_mode);
        enc_bytes = '0;
        if (cp <= ucc_pkg::CP_1B_MAX) begin
            enc_len      = 3'd1;
            enc_bytes[0] = cp[7:0];
        end else if (cp <= ucc_pkg::CP_2B_MAX) begin
            enc_len      = 3'd2;
            enc_bytes[0] = {3'b110, cp[10:6]};
            enc_bytes[1] = {2'b10, cp[5:0]};
        end else if (cp <= ucc_pkg::CP_3B_MAX) begin
            enc_len      = 3'd3;
            enc_bytes[0] = {4'b1110, cp[15:12]};
            enc_bytes[1] = {2'b10, cp[11:6]};
            enc_bytes[2] = {2'b10, cp[5:0]};
        end else begin
            enc_len      = 3'd4;
            enc_bytes[0] = {5'b11110, cp[20:18]};
            enc_bytes[1] = {2'b10, cp[17:12]};
            enc_bytes[2] = {2'b10, cp[11:6]};
            enc_bytes[3] = {2'b10, cp[5:0]};
        end
    end

    always_comb begin
        can_move = !r_out_valid || o_out.ready;
        move     = r_cur_valid && can_move;
        cur_free = !r_cur_valid || (move && r_left == 3'd1);
        o_pop    = i_q_valid && cur_free;

        n_cur_valid = r_cur_valid;
        n_bytes     = r_bytes;
        n_left      = r_left;
        if (o_pop) begin
            n_cur_valid = 1'b1;
            n_bytes     = enc_bytes;
            n_left      = enc_len;
        end else if (move) begin
            n_cur_valid = (r_left != 3'd1);
            n_bytes     = {8'h00, r_bytes[3], r_bytes[2], r_bytes[1]};
            n_left      = r_left - 3'd1;
        end

        n_out_valid = r_out_valid;
        if (move) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        o_out.valid       = r_out_valid;
        o_out.out_byte    = r_out_byte;
        o_out.byte_valid  = r_out_bv;
        o_out.run_last    = r_out_last;
        o_out.string_done = r_out_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_left      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_cur_valid <= n_cur_valid;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
        if (o_pop) begin
            r_empty <= i_q_data.empty;
            r_last  <= i_q_data.run_last;
            r_done  <= i_q_data.done;
        end
        if (move) begin
            r_out_byte <= r_bytes[0];
            r_out_bv   <= !r_empty;
            r_out_last <= r_last && (r_left == 3'd1);
            r_out_done <= r_done && (r_left == 3'd1);
        end
    end

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (r_left != 3'd0 && r_left <= 3'd4))
        else $error("byte count out of range for a live code point");

    a_empty_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.byte_valid) |-> (o_out.run_last && o_out.string_done))
        else $error("empty result that does not close the text");

endmodule

// ===== rtl/utf8_case_converter.sv =====
// ----------------------------------------------------------------------------
// utf8_case_converter
// streaming utf-8 decode, upper/lower case map and re-encode
// ----------------------------------------------------------------------------
// One input item is one text byte; each item yields zero to eight result
// bytes, the last of them flagged run_last and the last of the text flagged
// string_done. The front decodes an item in the cycle it is accepted and
// queues up to two code points; the back encoder sends one result byte per
// cycle while the output is ready, so the sustained rate is set by the bytes
// produced: one for an ascii byte, two for a stray byte or two-byte character,
// up to four for a four-byte character. An item that flushes a partial sequence
// as well as its own code point holds the input until the second code point
// moves from the spill register into the queue. The first result byte passes
// the queue, the current code point register and the output register. case_mode
// is written through i_cfg_we/i_cfg_wdata: 0 maps to upper case, 1 to lower.
// ----------------------------------------------------------------------------
module utf8_case_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    ucc_in_if.sink      i_in,
    ucc_out_if.source   o_out
);

    logic           r_case_mode;
    logic           q_push, q_full, q_valid, q_pop;
    ucc_pkg::t_job  q_wdata, q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_case_mode <= ucc_pkg::MODE_UPPER;
        end else if (i_cfg_we) begin
            r_case_mode <= i_cfg_wdata;
        end
    end

    ucc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_push_job (q_wdata)
    );

    ucc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_rdata),
        .i_pop   (q_pop)
    );

    ucc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_case_mode (r_case_mode),
        .i_q_valid   (q_valid),
        .i_q_data    (q_rdata),
        .o_pop       (q_pop),
        .o_out       (o_out)
    );

endmodule
